// ----- rtl/transformed_aabb_recompute_unit_macros.svh -----
// Assertion macros for the transformed AABB recompute unit.
// Expects clk and arst_n in the scope of the use; no other dependencies.
`ifndef TRANSFORMED_AABB_RECOMPUTE_UNIT_MACROS_SVH
`define TRANSFORMED_AABB_RECOMPUTE_UNIT_MACROS_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define TARU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define TARU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/taru_pkg.sv -----
// Shared types and constants for the transformed AABB recompute unit.
// No dependencies.
package taru_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned Q_W       = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic signed [Q_W-1:0] q_t;

	// Configuration register indexes
	localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
	localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
	localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
	localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
	localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
	localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;

	localparam q_t Q_MAX = 32'sh7fff_ffff;
	localparam q_t Q_MIN = 32'sh8000_0000;

	// Saturate a 34-bit signed sum to Q16.16 range.
	function automatic q_t sat34(input logic signed [33:0] v);
		q_t r;
		if (v > 34'(Q_MAX))
			r = Q_MAX;
		else if (v < 34'(Q_MIN))
			r = Q_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/transformed_aabb_recompute_unit.sv -----
// Transformed AABB recompute unit: top level, five-stage pipeline.
// Depends on taru_pkg and transformed_aabb_recompute_unit_macros.svh.
// Rate: one item per cycle while the output is not stalled; each beat is registered in stages 1 to 5 in turn.
// The local box (six registers, written on cfg_we) is transformed by the
// 3x3 matrix of each input beat. Per axis the extreme corners are found
// term by term: every matrix entry is multiplied by both the box minimum
// and maximum (18 parallel 32x32 multipliers in stage 1), and the smaller
// and larger shifted product of each pair is kept. Because the shift, the
// sum and the saturation are all monotonic, this gives the same min/max as
// searching all eight corners. Stages: 1 multiply, 2 shift and pick,
// 3 row sums and saturate, 4 half extent, 5 center plus position and
// saturate. Each stage has its own valid bit and moves when the stage
// after it has room, so bubbles close up under output backpressure and
// in_ready stays high while any stage is empty.
module transformed_aabb_recompute_unit
	import taru_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	// configuration write port
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  q_t       cfg_wdata,
	// input channel
	input  logic     in_valid,
	output logic     in_ready,
	input  q_t       rot_m00,
	input  q_t       rot_m01,
	input  q_t       rot_m02,
	input  q_t       rot_m10,
	input  q_t       rot_m11,
	input  q_t       rot_m12,
	input  q_t       rot_m20,
	input  q_t       rot_m21,
	input  q_t       rot_m22,
	input  q_t       pos_x,
	input  q_t       pos_y,
	input  q_t       pos_z,
	// output channel
	output logic     out_valid,
	input  logic     out_ready,
	output q_t       center_x,
	output q_t       center_y,
	output q_t       center_z,
	output q_t       half_x,
	output q_t       half_y,
	output q_t       half_z
);

	`include "transformed_aabb_recompute_unit_macros.svh"

	localparam int unsigned PROD_W = 2 * Q_W;          // exact product
	localparam int unsigned TERM_W = PROD_W - FRAC_BITS; // after the shift
	localparam int unsigned SUM_W  = TERM_W + 2;       // sum of three terms

	localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(Q_MAX);
	localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(Q_MIN);

	// ---------------- configuration ----------------
	q_t box_lo_q [3];
	q_t box_hi_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_lo_q[i] <= '0;
				box_hi_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOX_MIN_X: box_lo_q[0] <= cfg_wdata;
				CFG_BOX_MIN_Y: box_lo_q[1] <= cfg_wdata;
				CFG_BOX_MIN_Z: box_lo_q[2] <= cfg_wdata;
				CFG_BOX_MAX_X: box_hi_q[0] <= cfg_wdata;
				CFG_BOX_MAX_Y: box_hi_q[1] <= cfg_wdata;
				CFG_BOX_MAX_Z: box_hi_q[2] <= cfg_wdata;
				default: ; // unused indexes are dropped
			endcase
		end
	end

	// ---------------- handshake chain ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// A stage loads when it is empty or its contents move on this edge.
	assign en_s5 = !v_s5 || out_ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: products ----------------
	q_t m_in   [3][3];
	q_t pos_in [3];

	always_comb begin
		m_in[0][0] = rot_m00; m_in[0][1] = rot_m01; m_in[0][2] = rot_m02;
		m_in[1][0] = rot_m10; m_in[1][1] = rot_m11; m_in[1][2] = rot_m12;
		m_in[2][0] = rot_m20; m_in[2][1] = rot_m21; m_in[2][2] = rot_m22;
		pos_in[0]  = pos_x;
		pos_in[1]  = pos_y;
		pos_in[2]  = pos_z;
	end

	logic signed [PROD_W-1:0] plo_s1 [3][3];
	logic signed [PROD_W-1:0] phi_s1 [3][3];
	q_t                       pos_s1 [3];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					plo_s1[r][c] <= PROD_W'(m_in[r][c]) * PROD_W'(box_lo_q[c]);
					phi_s1[r][c] <= PROD_W'(m_in[r][c]) * PROD_W'(box_hi_q[c]);
				end
				pos_s1[r] <= pos_in[r];
			end
		end
	end

	// ---------------- stage 2: shift, pick smaller/larger term ----------------
	logic signed [TERM_W-1:0] tlo [3][3];
	logic signed [TERM_W-1:0] thi [3][3];
	logic signed [TERM_W-1:0] mn_s2 [3][3];
	logic signed [TERM_W-1:0] mx_s2 [3][3];
	q_t                       pos_s2 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				// arithmetic shift = floor; top bits of the product
				tlo[r][c] = plo_s1[r][c][PROD_W-1:FRAC_BITS];
				thi[r][c] = phi_s1[r][c][PROD_W-1:FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (tlo[r][c] < thi[r][c]) begin
						mn_s2[r][c] <= tlo[r][c];
						mx_s2[r][c] <= thi[r][c];
					end else begin
						mn_s2[r][c] <= thi[r][c];
						mx_s2[r][c] <= tlo[r][c];
					end
				end
				pos_s2[r] <= pos_s1[r];
			end
		end
	end

	// ---------------- stage 3: row sums, saturate ----------------
	logic signed [SUM_W-1:0] sum_lo [3];
	logic signed [SUM_W-1:0] sum_hi [3];
	q_t lo_s3  [3];
	q_t hi_s3  [3];
	q_t pos_s3 [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_lo[r] = SUM_W'(mn_s2[r][0]) + SUM_W'(mn_s2[r][1]) + SUM_W'(mn_s2[r][2]);
			sum_hi[r] = SUM_W'(mx_s2[r][0]) + SUM_W'(mx_s2[r][1]) + SUM_W'(mx_s2[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int r = 0; r < 3; r++) begin
				if (sum_lo[r] > SUM_MAX)
					lo_s3[r] <= Q_MAX;
				else if (sum_lo[r] < SUM_MIN)
					lo_s3[r] <= Q_MIN;
				else
					lo_s3[r] <= sum_lo[r][Q_W-1:0];
				if (sum_hi[r] > SUM_MAX)
					hi_s3[r] <= Q_MAX;
				else if (sum_hi[r] < SUM_MIN)
					hi_s3[r] <= Q_MIN;
				else
					hi_s3[r] <= sum_hi[r][Q_W-1:0];
				pos_s3[r] <= pos_s2[r];
			end
		end
	end

	// ---------------- stage 4: half extent ----------------
	logic signed [Q_W:0] diff [3];
	q_t half_s4 [3];
	q_t hi_s4   [3];
	q_t pos_s4  [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			diff[r] = (Q_W+1)'(hi_s3[r]) - (Q_W+1)'(lo_s3[r]);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int r = 0; r < 3; r++) begin
				half_s4[r] <= diff[r][Q_W:1]; // diff >= 0, always fits
				hi_s4[r]   <= hi_s3[r];
				pos_s4[r]  <= pos_s3[r];
			end
		end
	end

	// ---------------- stage 5: center, output register ----------------
	logic signed [Q_W+1:0] ctr_sum [3];
	q_t ctr_s5  [3];
	q_t half_s5 [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			ctr_sum[r] = (Q_W+2)'(hi_s4[r]) - (Q_W+2)'(half_s4[r]) + (Q_W+2)'(pos_s4[r]);
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int r = 0; r < 3; r++) begin
				ctr_s5[r]  <= sat34(ctr_sum[r]);
				half_s5[r] <= half_s4[r];
			end
		end
	end

	assign out_valid = v_s5;
	assign center_x  = ctr_s5[0];
	assign center_y  = ctr_s5[1];
	assign center_z  = ctr_s5[2];
	assign half_x    = half_s5[0];
	assign half_y    = half_s5[1];
	assign half_z    = half_s5[2];

	// ---------------- assertions ----------------
	`TARU_ASSERT(a_lo_le_hi, v_s3 |-> (lo_s3[0] <= hi_s3[0] && lo_s3[1] <= hi_s3[1] && lo_s3[2] <= hi_s3[2]), "row min above row max")
	`TARU_ASSERT(a_half_nonneg, out_valid |-> (!half_x[Q_W-1] && !half_y[Q_W-1] && !half_z[Q_W-1]), "negative half extent")
	`TARU_ASSERT(a_s2_hold, (v_s2 && !en_s3) |=> (v_s2 && $stable(mn_s2[0][0]) && $stable(mx_s2[2][2])), "stalled stage 2 lost its data")
	`TARU_ASSERT_ALWAYS(a_ready_when_empty, (!v_s1 || !v_s5) |-> in_ready, "input blocked with a free stage")

endmodule
